/* src/ctr_pkg.sv */
package ctr_pkg;

   localparam int VAL_W      = 256;
   localparam int DIV_STEPS  = 4;                  // quotient bits per divider stage
   localparam int DIV_STAGES = VAL_W / DIV_STEPS;
   localparam int CSR_AW     = 6;
   localparam int CSR_DW     = 64;

   // register indexes, byte address is 8*index
   localparam logic [2:0] CSR_NO_RETARGET     = 3'd0;
   localparam logic [2:0] CSR_TARGET_TIMESPAN = 3'd1;
   localparam logic [2:0] CSR_POW_LIMIT_W0    = 3'd2;
   localparam logic [2:0] CSR_POW_LIMIT_W1    = 3'd3;
   localparam logic [2:0] CSR_POW_LIMIT_W2    = 3'd4;
   localparam logic [2:0] CSR_POW_LIMIT_W3    = 3'd5;

   localparam logic [31:0] TIMESPAN_RST  = 32'd1209600;
   localparam logic [63:0] LIMIT_LOW_RST = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIMIT_TOP_RST = 64'h0000_0000_FFFF_FFFF;

   // exponent never exceeds this after re-encoding a 256-bit value
   localparam logic [7:0] MAX_EXPONENT = 8'd33;

   typedef struct packed {
      logic        halve;
      logic [31:0] old_compact;
   } side_type;

endpackage

/* src/ctr_front.sv */
module ctr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [31:0]                old_compact,
   input  logic [31:0]                last_time,
   input  logic [31:0]                first_time,
   input  logic [31:0]                timespan,
   input  logic [ctr_pkg::VAL_W-1:0]  limit,
   output logic                       out_valid,
   output logic [ctr_pkg::VAL_W-1:0]  out_val,
   output ctr_pkg::side_type          out_side
);

   // limit smeared down from its top bit; tracks config every cycle
   logic [ctr_pkg::VAL_W-1:0] smear_ff, smear_in;

   // stage 0: clamp span, expand compact word into (mantissa, shift)
   logic        v0_ff;
   logic [33:0] span0_ff, span0_in;
   logic [22:0] m0_ff, m0_in;
   logic [7:0]  s0_ff, s0_in;
   logic [31:0] old0_ff;
   // stage 1: full-width value for the halve test
   logic        v1_ff;
   logic [ctr_pkg::VAL_W-1:0] val1_ff;
   logic [33:0] span1_ff;
   logic [22:0] m1_ff;
   logic [7:0]  s1_ff;
   logic [31:0] old1_ff;
   // stage 2: halve applied
   logic        v2_ff;
   logic [33:0] span2_ff;
   logic [22:0] m2_ff, m2_in;
   logic [7:0]  s2_ff, s2_in;
   ctr_pkg::side_type side2_ff, side2_in;
   // stage 3: product
   logic        v3_ff;
   logic [56:0] prod3_ff;
   logic [7:0]  s3_ff;
   ctr_pkg::side_type side3_ff;
   // stage 4: product placed at its shift
   logic        v4_ff;
   logic [ctr_pkg::VAL_W-1:0] val4_ff;
   ctr_pkg::side_type side4_ff;

   always_comb begin
      smear_in = limit;
      for (int k = 0; k < 8; k++) begin
         smear_in = smear_in | (smear_in >> (1 << k));
      end
   end

   always_comb begin
      logic [32:0] diff;
      logic [34:0] span_s, lo_s, hi_s;
      logic [7:0]  size, sfull;
      logic [22:0] word;
      diff   = {1'b0, last_time} - {1'b0, first_time};
      span_s = {{2{diff[32]}}, diff};
      lo_s   = {5'b0, timespan[31:2]};
      hi_s   = {1'b0, timespan, 2'b00};
      if ($signed(span_s) < $signed(lo_s)) begin
         span0_in = lo_s[33:0];
      end else if ($signed(span_s) > $signed(hi_s)) begin
         span0_in = hi_s[33:0];
      end else begin
         span0_in = span_s[33:0];
      end

      size  = old_compact[31:24];
      word  = old_compact[22:0];
      sfull = size - 8'd3;
      m0_in = '0;
      s0_in = '0;
      case (size)
         8'd0: m0_in = '0;
         8'd1: m0_in = word >> 16;
         8'd2: m0_in = word >> 8;
         8'd3: m0_in = word;
         default: begin
            if (sfull < 8'd32) begin
               s0_in = {sfull[4:0], 3'b000};
               // drop mantissa bits that land past bit 255
               for (int b = 0; b < 23; b++) begin
                  m0_in[b] = word[b] & ((9'(b) + {1'b0, s0_in}) < 9'd256);
               end
            end
         end
      endcase
   end

   always_comb begin
      logic halve;
      halve = (|smear_ff) && (|(val1_ff & ~(smear_ff >> 1)));
      m2_in = m1_ff;
      s2_in = s1_ff;
      if (halve) begin
         if (s1_ff != 8'd0) begin
            s2_in = s1_ff - 8'd1;
         end else begin
            m2_in = m1_ff >> 1;
         end
      end
      side2_in.halve       = halve;
      side2_in.old_compact = old1_ff;
   end

   always_ff @(posedge clock) begin
      smear_ff <= smear_in;
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         span0_ff  <= span0_in;
         m0_ff     <= m0_in;
         s0_ff     <= s0_in;
         old0_ff   <= old_compact;
         val1_ff   <= ctr_pkg::VAL_W'(m0_ff) << s0_ff;
         span1_ff  <= span0_ff;
         m1_ff     <= m0_ff;
         s1_ff     <= s0_ff;
         old1_ff   <= old0_ff;
         span2_ff  <= span1_ff;
         m2_ff     <= m2_in;
         s2_ff     <= s2_in;
         side2_ff  <= side2_in;
         prod3_ff  <= 57'(m2_ff) * 57'(span2_ff);
         s3_ff     <= s2_ff;
         side3_ff  <= side2_ff;
         val4_ff   <= ctr_pkg::VAL_W'(prod3_ff) << s3_ff;
         side4_ff  <= side3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_val   = val4_ff;
   assign out_side  = side4_ff;

endmodule

/* src/ctr_div_stage.sv */
module ctr_div_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [ctr_pkg::VAL_W-1:0]  x_in,
   input  logic [31:0]                rem_in,
   input  ctr_pkg::side_type          side_in,
   input  logic [31:0]                divisor,
   output logic                       out_valid,
   output logic [ctr_pkg::VAL_W-1:0]  x_out,
   output logic [31:0]                rem_out,
   output ctr_pkg::side_type          side_out
);

   // x shifts dividend bits out at the top and quotient bits in at the bottom
   logic                      valid_ff;
   logic [ctr_pkg::VAL_W-1:0] x_ff, x_in_c;
   logic [31:0]               rem_ff, rem_in_c;
   ctr_pkg::side_type         side_ff;

   always_comb begin
      logic [32:0] t;
      logic        q;
      x_in_c   = x_in;
      rem_in_c = rem_in;
      for (int k = 0; k < ctr_pkg::DIV_STEPS; k++) begin
         t = {rem_in_c, x_in_c[ctr_pkg::VAL_W-1]};
         if (t >= {1'b0, divisor}) begin
            rem_in_c = 32'(t - {1'b0, divisor});
            q        = 1'b1;
         end else begin
            rem_in_c = t[31:0];
            q        = 1'b0;
         end
         x_in_c = {x_in_c[ctr_pkg::VAL_W-2:0], q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in_c;
         rem_ff  <= rem_in_c;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign rem_out   = rem_ff;
   assign side_out  = side_ff;

endmodule

/* src/ctr_back.sv */
module ctr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [ctr_pkg::VAL_W-1:0]  quot,
   input  ctr_pkg::side_type          side_in,
   input  logic [ctr_pkg::VAL_W-1:0]  limit,
   input  logic                       no_retarget,
   output logic                       out_valid,
   output logic [31:0]                new_compact
);

   // b0: undo halving, b1: clamp to limit, b2: byte length, b3: pack
   logic                      v0_ff, v1_ff, v2_ff, v3_ff;
   logic [ctr_pkg::VAL_W-1:0] val0_ff, val1_ff, val2_ff;
   logic [31:0]               old0_ff, old1_ff, old2_ff;
   logic [5:0]                n2_ff, n2_in;
   logic [31:0]               res3_ff, res3_in;

   always_comb begin
      n2_in = '0;
      for (int i = 0; i < ctr_pkg::VAL_W / 8; i++) begin
         if (|val1_ff[8*i +: 8]) begin
            n2_in = 6'(i + 1);
         end
      end
   end

   always_comb begin
      logic [ctr_pkg::VAL_W+23:0] padded;
      logic [23:0]                c24;
      logic [7:0]                 e;
      padded = {val2_ff, 24'b0};
      c24    = padded[{n2_ff, 3'b000} +: 24];
      e      = {2'b00, n2_ff};
      if (c24[23]) begin
         c24 = {8'b0, c24[23:8]};
         e   = e + 8'd1;
      end
      res3_in = no_retarget ? old2_ff : {e, c24};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val0_ff <= side_in.halve ? {quot[ctr_pkg::VAL_W-2:0], 1'b0} : quot;
         old0_ff <= side_in.old_compact;
         val1_ff <= (val0_ff > limit) ? limit : val0_ff;
         old1_ff <= old0_ff;
         val2_ff <= val1_ff;
         n2_ff   <= n2_in;
         old2_ff <= old1_ff;
         res3_ff <= res3_in;
      end
   end

   assign out_valid   = v3_ff;
   assign new_compact = res3_ff;

endmodule

/* src/compact_target_retarget_core.sv */
// Compact target retarget: one result word per request word.
// Pipeline from request accept to result valid: 5 front stages
// (span clamp, expand, halve test, multiply, place), 64 divider stages of
// 4 quotient bits each, 4 back stages (unhalve, clamp, length, pack).
// Throughput one word per cycle; a stalled result freezes the whole pipe.
// Synchronous active-high reset empties the pipe and loads register defaults.
module compact_target_retarget_core (
   input  logic                        clock,
   input  logic                        reset,
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [95:0]                 req_tdata,   // old_compact, last_time, first_time
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // new_compact
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ctr_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ctr_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ctr_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   logic                      no_retarget_ff, no_retarget_in;
   logic [31:0]               timespan_ff, timespan_in;
   logic [ctr_pkg::VAL_W-1:0] limit_ff, limit_in;
   logic                      csr_wr;
   logic [2:0]                csr_idx;
   logic [31:0]               divisor;
   logic                      adv;

   // divider chain taps
   logic                      dv   [ctr_pkg::DIV_STAGES+1];
   logic [ctr_pkg::VAL_W-1:0] dx   [ctr_pkg::DIV_STAGES+1];
   logic [31:0]               drem [ctr_pkg::DIV_STAGES+1];
   ctr_pkg::side_type         dside[ctr_pkg::DIV_STAGES+1];

   // ---------------- register file ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      no_retarget_in = no_retarget_ff;
      timespan_in    = timespan_ff;
      limit_in       = limit_ff;
      if (csr_wr) begin
         case (csr_idx)
            ctr_pkg::CSR_NO_RETARGET:     no_retarget_in   = csr_pwdata[0];
            ctr_pkg::CSR_TARGET_TIMESPAN: timespan_in      = csr_pwdata[31:0];
            ctr_pkg::CSR_POW_LIMIT_W0:    limit_in[63:0]   = csr_pwdata;
            ctr_pkg::CSR_POW_LIMIT_W1:    limit_in[127:64] = csr_pwdata;
            ctr_pkg::CSR_POW_LIMIT_W2:    limit_in[191:128] = csr_pwdata;
            ctr_pkg::CSR_POW_LIMIT_W3:    limit_in[255:192] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ctr_pkg::CSR_NO_RETARGET:     csr_prdata = {63'b0, no_retarget_ff};
         ctr_pkg::CSR_TARGET_TIMESPAN: csr_prdata = {32'b0, timespan_ff};
         ctr_pkg::CSR_POW_LIMIT_W0:    csr_prdata = limit_ff[63:0];
         ctr_pkg::CSR_POW_LIMIT_W1:    csr_prdata = limit_ff[127:64];
         ctr_pkg::CSR_POW_LIMIT_W2:    csr_prdata = limit_ff[191:128];
         ctr_pkg::CSR_POW_LIMIT_W3:    csr_prdata = limit_ff[255:192];
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         no_retarget_ff <= 1'b0;
         timespan_ff    <= ctr_pkg::TIMESPAN_RST;
         limit_ff       <= {ctr_pkg::LIMIT_TOP_RST, ctr_pkg::LIMIT_LOW_RST,
                            ctr_pkg::LIMIT_LOW_RST, ctr_pkg::LIMIT_LOW_RST};
      end else begin
         no_retarget_ff <= no_retarget_in;
         timespan_ff    <= timespan_in;
         limit_ff       <= limit_in;
      end
   end

   // zero timespan divides by one (dividend is already zero then)
   assign divisor = (timespan_ff == 32'd0) ? 32'd1 : timespan_ff;

   // ---------------- pipeline ----------------
   // one global enable: pipe moves whenever the output register can take a word
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   ctr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid),
      .old_compact (req_tdata[31:0]),
      .last_time   (req_tdata[63:32]),
      .first_time  (req_tdata[95:64]),
      .timespan    (timespan_ff),
      .limit       (limit_ff),
      .out_valid   (dv[0]),
      .out_val     (dx[0]),
      .out_side    (dside[0])
   );

   assign drem[0] = '0;

   // restoring long division, 4 quotient bits per stage
   for (genvar g = 0; g < ctr_pkg::DIV_STAGES; g++) begin : g_div
      ctr_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv[g]),
         .x_in      (dx[g]),
         .rem_in    (drem[g]),
         .side_in   (dside[g]),
         .divisor   (divisor),
         .out_valid (dv[g+1]),
         .x_out     (dx[g+1]),
         .rem_out   (drem[g+1]),
         .side_out  (dside[g+1])
      );
   end

   ctr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dv[ctr_pkg::DIV_STAGES]),
      .quot        (dx[ctr_pkg::DIV_STAGES]),
      .side_in     (dside[ctr_pkg::DIV_STAGES]),
      .limit       (limit_ff),
      .no_retarget (no_retarget_ff),
      .out_valid   (rsp_tvalid),
      .new_compact (rsp_tdata)
   );

   // ---------------- checks ----------------
   // re-encoded word never carries the sign bit
   a_sign_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !no_retarget_ff |-> !rsp_tdata[23])
      else $error("sign bit set in re-encoded target");

   // exponent bounded by a 256-bit value
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !no_retarget_ff |-> rsp_tdata[31:24] <= ctr_pkg::MAX_EXPONENT)
      else $error("exponent out of range");

   // zero exponent only for a zero target
   a_zero_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !no_retarget_ff && rsp_tdata[31:24] == 8'd0
         |-> rsp_tdata[23:0] == 24'd0)
      else $error("nonzero mantissa with zero exponent");

endmodule

/* sim/compact_target_retarget_core_tb.sv */
module compact_target_retarget_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // pipe is 73 deep; drain margin and stall watchdog
   localparam int DRAIN_CYCLES = 150;
   localparam int STALL_LIMIT  = 5000;
   localparam int RAND_WORDS   = 264;   // per full phase, eight full-phase equivalents

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [95:0]                  req_tdata;     // old_compact, last_time, first_time (low bits up)
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [31:0]                  rsp_tdata;     // new_compact
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [ctr_pkg::CSR_AW-1:0]   csr_paddr;
   logic [ctr_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [ctr_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   compact_target_retarget_core dut (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // shadow copy of the register file
   logic         shadow_no_retarget;
   logic [31:0]  shadow_timespan;
   logic [255:0] shadow_limit;

   logic [31:0]  target_q[$];     // expected new_compact words, oldest first
   int           mismatches;
   int           stall_count;
   bit           burst_mode;      // no idling on either side when set

   function automatic int bit_length(input logic [255:0] v);
      for (int i = 255; i >= 0; i--)
         if (v[i]) return i + 1;
      return 0;
   endfunction

   // new compact target for one request word under the shadow registers
   function automatic logic [31:0] retarget_compact(input logic [31:0] old_c,
                                                    input logic [31:0] last_t,
                                                    input logic [31:0] first_t);
      logic signed [63:0] span, lo, hi, tsp;
      logic [255:0]       val;
      logic [22:0]        mant;
      int                 expo, n, lim_len;
      logic               halve;
      logic [31:0]        c;
      if (shadow_no_retarget) return old_c;
      tsp  = $signed({32'd0, shadow_timespan});
      span = $signed({32'd0, last_t}) - $signed({32'd0, first_t});
      lo   = tsp / 4;
      hi   = tsp * 4;
      if (span < lo) span = lo;
      if (span > hi) span = hi;
      // expand: sign bit ignored, bits past 255 fall off
      expo = old_c[31:24];
      mant = old_c[22:0];
      if (expo <= 3) val = 256'(mant >> (8 * (3 - expo)));
      else           val = 256'(mant) << (8 * (expo - 3));
      // a target at least as long as the limit is halved around the scaling
      lim_len = bit_length(shadow_limit);
      halve   = (lim_len != 0) && (bit_length(val) >= lim_len);
      if (halve) val = val >> 1;
      val = val * 256'(span);                      // wraps mod 2^256
      val = val / ((tsp == 0) ? 256'd1 : 256'(tsp));
      if (halve) val = val << 1;
      if (val > shadow_limit) val = shadow_limit;
      // re-encode
      n = (bit_length(val) + 7) / 8;
      if (n <= 3) c = val[31:0] << (8 * (3 - n));
      else        c = 32'(val >> (8 * (n - 3)));
      if (c[23]) begin
         c = c >> 8;
         n++;
      end
      return {8'(n), c[23:0]};
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (idx)
         ctr_pkg::CSR_NO_RETARGET:     shadow_no_retarget    = value[0];
         ctr_pkg::CSR_TARGET_TIMESPAN: shadow_timespan       = value[31:0];
         ctr_pkg::CSR_POW_LIMIT_W0:    shadow_limit[63:0]    = value;
         ctr_pkg::CSR_POW_LIMIT_W1:    shadow_limit[127:64]  = value;
         ctr_pkg::CSR_POW_LIMIT_W2:    shadow_limit[191:128] = value;
         ctr_pkg::CSR_POW_LIMIT_W3:    shadow_limit[255:192] = value;
         default: ;
      endcase
   endtask

   task automatic set_limit(input logic [255:0] lim);
      csr_write(ctr_pkg::CSR_POW_LIMIT_W0, lim[63:0]);
      csr_write(ctr_pkg::CSR_POW_LIMIT_W1, lim[127:64]);
      csr_write(ctr_pkg::CSR_POW_LIMIT_W2, lim[191:128]);
      csr_write(ctr_pkg::CSR_POW_LIMIT_W3, lim[255:192]);
   endtask

   // one request word; valid stays high across back-to-back words
   task automatic send_word(input logic [31:0] old_c, input logic [31:0] last_t,
                            input logic [31:0] first_t, input bit fixed,
                            input logic [31:0] fixed_val);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {first_t, last_t, old_c};
      do @(posedge clock); while (!req_tready);
      target_q.push_back(fixed ? fixed_val : retarget_compact(old_c, last_t, first_t));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (target_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // random word: mostly plausible exponents and spans near the timespan
   task automatic send_random();
      logic [31:0] old_c, first_t, last_t;
      logic [63:0] reach;
      if ($urandom_range(0, 3) == 0) old_c = $urandom;
      else old_c = {8'($urandom_range(0, 34)), 24'($urandom)};
      first_t = $urandom;
      if ($urandom_range(0, 4) == 0) begin
         last_t = $urandom;
      end else begin
         reach  = 64'(shadow_timespan) * 5 + 1;
         if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
         last_t = first_t + 32'($urandom_range(0, 32'(reach)));
      end
      send_word(old_c, last_t, first_t, 1'b0, 32'd0);
   endtask

   typedef struct {
      logic [31:0] old_c;
      logic [31:0] last_t;
      logic [31:0] first_t;
      bit          fixed;
      logic [31:0] fixed_val;
   } vec_type;

   // directed words under reset defaults (timespan 1209600, limit 2^224-1)
   vec_type directed[] = '{
      '{32'h0000_0000, 32'd0,          32'd0,          1, 32'h0000_0000}, // zero target
      '{32'h1D00_FFFF, 32'd1209600,    32'd0,          1, 32'h1D00_FFFF}, // on schedule
      '{32'h1D00_FFFF, 32'hFFFF_FFFF,  32'd0,          1, 32'h1D00_FFFF}, // clamps to limit
      '{32'h1D00_FFFF, 32'd0,          32'hFFFF_FFFF,  0, 32'd0},         // negative elapsed
      '{32'h1B04_04CB, 32'd100,        32'd200,        0, 32'd0},
      '{32'h1B84_04CB, 32'd1209600,    32'd0,          0, 32'd0},         // sign bit set
      '{32'h0112_3456, 32'd1209600,    32'd0,          0, 32'd0},         // short exponents
      '{32'h0212_3456, 32'd604800,     32'd0,          0, 32'd0},
      '{32'h0312_3456, 32'd4838400,    32'd0,          0, 32'd0},
      '{32'h0412_3456, 32'd302400,     32'd0,          0, 32'd0},
      '{32'h2100_FFFF, 32'd302400,     32'd0,          0, 32'd0},
      '{32'h2200_0001, 32'd302400,     32'd0,          0, 32'd0},
      '{32'hFF7F_FFFF, 32'd1209600,    32'd0,          0, 32'd0},         // huge exponent
      '{32'h2A7F_FFFF, 32'd302400,     32'd0,          0, 32'd0},         // shifted out entirely
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  0, 32'd0},         // all ones
      '{32'h1C7F_FFFF, 32'd4838400,    32'd0,          0, 32'd0},         // halving path
      '{32'h1D7F_FFFF, 32'd302400,     32'd0,          0, 32'd0},
      '{32'h1800_8000, 32'd1209601,    32'd1,          0, 32'd0},         // encode carry
      '{32'h0000_0000, 32'hFFFF_FFFF,  32'd0,          0, 32'd0}
   };

   // stimulus and configuration phases
   initial begin
      logic [255:0] rnd_limit;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_mode  = 1'b0;
      shadow_no_retarget = 1'b0;
      shadow_timespan    = ctr_pkg::TIMESPAN_RST;
      shadow_limit       = {ctr_pkg::LIMIT_TOP_RST, ctr_pkg::LIMIT_LOW_RST,
                            ctr_pkg::LIMIT_LOW_RST, ctr_pkg::LIMIT_LOW_RST};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_word(directed[i].old_c, directed[i].last_t, directed[i].first_t,
                   directed[i].fixed, directed[i].fixed_val);
      repeat (RAND_WORDS) send_random();
      drain();   // sender holds off until every result is back

      // bypass: old word returned as is
      csr_write(ctr_pkg::CSR_NO_RETARGET, 64'd1);
      burst_mode = 1'b1;
      repeat (RAND_WORDS) send_random();
      drain();
      burst_mode = 1'b0;
      csr_write(ctr_pkg::CSR_NO_RETARGET, 64'd0);

      // zero timespan: scaled target collapses to zero
      csr_write(ctr_pkg::CSR_TARGET_TIMESPAN, 64'd0);
      repeat (RAND_WORDS / 2) send_random();
      drain();

      // widest timespan, all-ones limit
      csr_write(ctr_pkg::CSR_TARGET_TIMESPAN, 64'hFFFF_FFFF);
      set_limit({256{1'b1}});
      repeat (RAND_WORDS) send_random();
      drain();

      // zero limit: everything clamps to zero
      set_limit('0);
      csr_write(ctr_pkg::CSR_TARGET_TIMESPAN, 64'd1);
      repeat (RAND_WORDS / 2) send_random();
      drain();

      // random settings
      repeat (4) begin
         rnd_limit = {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
         rnd_limit = rnd_limit >> $urandom_range(0, 255);
         set_limit(rnd_limit);
         csr_write(ctr_pkg::CSR_TARGET_TIMESPAN, 64'($urandom_range(1, 32'hFFFF_FFFF)));
         burst_mode = $urandom_range(0, 1);
         repeat (RAND_WORDS) send_random();
         drain();
      end
      burst_mode = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && target_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // result side back-pressure
   initial begin
      int wait_cycles;
      rsp_tready = 1'b0;
      forever begin
         wait_cycles = burst_mode ? 0 : $urandom_range(0, 3);
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (target_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = target_q.pop_front();
            if (rsp_tdata !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("new_compact mismatch: expected %h got %h", want, rsp_tdata);
            end
         end
      end
   end

   // watchdog: cycles with no accepted word on either stream and no register access
   initial begin
      mismatches  = 0;
      stall_count = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= STALL_LIMIT) break;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
